// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LUD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lud checker: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define LUD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lud checker: property violated");

`endif

// ===== rtl/core/lud_pkg.sv =====
// Shared constants, types and helper functions of the LU decomposition core.
`timescale 1ns / 1ps
`default_nettype none

package lud_pkg;

	localparam int MAX_SIZE = 8;
	localparam int IDX_W    = $clog2(MAX_SIZE);
	localparam int SIZE_W   = 4;
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
	localparam int DATA_W   = 32;
	localparam int FRAC_W   = 24;
	localparam int NUM_W    = DATA_W + FRAC_W;
	localparam int ACC_W    = 48;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int CNT_W    = $clog2(NUM_W);

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] ONE_LSB = {{(DATA_W-1){1'b0}}, 1'b1};

	typedef logic [IDX_W-1:0] idx_t;

	// Source of the data written into the matrix store.
	typedef enum logic [2:0] {
		WR_ELEM,
		WR_ACC,
		WR_ONE,
		WR_DIV,
		WR_RDA,
		WR_RDB
	} wr_sel_t;

	// What the shared divider computes.
	typedef enum logic {
		DIV_MERIT,
		DIV_LOWER
	} div_mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      ld_en;
		logic      ld_row_end;
		logic      rd_en;
		idx_t      a_row;
		idx_t      a_col;
		idx_t      b_row;
		idx_t      b_col;
		logic      acc_load;
		logic      mac_mul;
		logic      acc_sub;
		logic      wr_en;
		idx_t      wr_row;
		idx_t      wr_col;
		wr_sel_t   wr_sel;
		logic      div_start;
		div_mode_t div_mode;
		logic      best_clr;
		idx_t      best_row;
		idx_t      sc_row;
		logic      swap;
		logic      sign_clr;
		logic      piv_cap;
		logic      out_load;
		logic      out_sing;
		logic      out_last;
		idx_t      out_row;
		idx_t      out_col;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic singular;
		logic rda_zero;
		idx_t best_idx;
	} status_t;

	// Magnitude of a two's complement word, as an unsigned word.
	function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? (~x + ONE_LSB) : x;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lu_decompose_partial_pivot_core.sv =====
// Top level of the LU decomposition core with scaled partial pivoting.
//
// Input channel: one signed Q8.24 word per accepted item (in_valid high, in_stall
// low), row-major, n*n words for an n x n matrix. The user writes the size register
// through cfg_write_en/cfg_write_data only while idle (not enforced by the core);
// a write restarts loading. Size zero acts as one, sizes above eight as eight.
// After the last word the core stalls its input and decomposes: each entry reads
// its element, loads the accumulator, subtracts one product per multiply-accumulate
// and writes back; each pivot merit and each lower factor uses the shared
// one-bit-per-cycle divider, which dominates the run time. Each row swap exchanges
// two rows word by word. The result channel then carries n*n words row-major, each
// read and loaded into the result register when free, last set on the final
// one. A matrix with an all-zero row gives a single word with singular and last.
// A stalled result word holds; the result register frees once it is taken, and
// the next matrix can load while the final word still waits.
// Reset clears the load position, the sign and the valid flag, and sets size 8.
`timescale 1ns / 1ps
`default_nettype none

module lu_decompose_partial_pivot_core (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_write_en,
	input  wire [lud_pkg::SIZE_W-1:0]              cfg_write_data,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire logic signed [lud_pkg::DATA_W-1:0] element,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic signed [lud_pkg::DATA_W-1:0]      value,
	output logic [lud_pkg::IDX_W-1:0]              row,
	output logic [lud_pkg::IDX_W-1:0]              column,
	output logic                                   det_negative,
	output logic                                   singular,
	output logic                                   last
);

	lud_pkg::cmd_t    cmd;
	lud_pkg::status_t status;

	// Sequencer.
	lud_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.status        (status)
	);

	// Storage and arithmetic.
	lud_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.element     (element),
		.status      (status),
		.value       (value),
		.row         (row),
		.column      (column),
		.det_negative(det_negative),
		.singular    (singular),
		.last        (last)
	);

endmodule

`default_nettype wire

// ===== rtl/core/lud_dp.sv =====
// Datapath: matrix store, multiply-accumulate, shared divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module lud_dp (
	input  wire                                clk,
	input  wire                                arst_n,
	input  lud_pkg::cmd_t                      cmd,
	input  wire logic signed [lud_pkg::DATA_W-1:0] element,
	output lud_pkg::status_t                   status,
	output logic signed [lud_pkg::DATA_W-1:0]  value,
	output logic [lud_pkg::IDX_W-1:0]          row,
	output logic [lud_pkg::IDX_W-1:0]          column,
	output logic                               det_negative,
	output logic                               singular,
	output logic                               last
);

	logic [lud_pkg::DATA_W-1:0] mem_q [lud_pkg::DEPTH];
	logic [lud_pkg::DATA_W-1:0] rda_q;
	logic [lud_pkg::DATA_W-1:0] rdb_q;
	logic [lud_pkg::DATA_W-1:0] scale_q [lud_pkg::MAX_SIZE];
	logic [lud_pkg::DATA_W-1:0] scale_rd;
	logic [lud_pkg::DATA_W-1:0] rowmax_q;
	logic [lud_pkg::DATA_W-1:0] rowmax_new;
	logic [lud_pkg::DATA_W-1:0] elem_mag;
	logic                       zero_q;
	logic                       sign_q;

	logic signed [lud_pkg::ACC_W-1:0]  acc_q;
	logic signed [lud_pkg::PROD_W-1:0] prod_s1;
	logic [lud_pkg::DATA_W-1:0]        acc_sat;
	logic                              acc_ovf;
	logic [lud_pkg::DATA_W-1:0]        v_q;
	logic [lud_pkg::DATA_W-1:0]        piv_q;
	logic [lud_pkg::DATA_W-1:0]        wr_data;

	logic [lud_pkg::NUM_W-1:0]  dnum_q;
	logic [lud_pkg::DATA_W-1:0] drem_q;
	logic [lud_pkg::DATA_W-1:0] dden_q;
	logic                       dneg_q;
	lud_pkg::div_mode_t         dmode_q;
	logic [lud_pkg::CNT_W-1:0]  dcnt_q;
	logic                       dbusy_q;
	logic                       ddone_q;
	logic [lud_pkg::DATA_W:0]   trial;
	logic [lud_pkg::DATA_W:0]   diff;
	logic                       trial_ge;
	logic [lud_pkg::DATA_W-1:0] qsat;
	logic                       q_hi;
	logic                       q_neg_ovf;
	logic [lud_pkg::DATA_W-1:0] lres_q;
	logic [lud_pkg::DATA_W-1:0] best_merit_q;
	lud_pkg::idx_t              best_q;

	// Running row maximum while a matrix is loaded.
	assign elem_mag   = lud_pkg::mag_of(element);
	assign rowmax_new = (cmd.wr_col == '0 || elem_mag > rowmax_q) ? elem_mag : rowmax_q;
	assign scale_rd   = scale_q[cmd.sc_row];

	// Saturation of the accumulator to the signed word range.
	assign acc_ovf = !((&acc_q[lud_pkg::ACC_W-1:lud_pkg::DATA_W-1]) ||
		(~|acc_q[lud_pkg::ACC_W-1:lud_pkg::DATA_W-1]));
	assign acc_sat = acc_ovf ? (acc_q[lud_pkg::ACC_W-1] ? lud_pkg::SAT_MIN : lud_pkg::SAT_MAX)
		: acc_q[lud_pkg::DATA_W-1:0];

	// Write data selection for the single write port.
	always_comb begin
		case (cmd.wr_sel)
			lud_pkg::WR_ELEM: wr_data = element;
			lud_pkg::WR_ACC:  wr_data = acc_sat;
			lud_pkg::WR_ONE:  wr_data = lud_pkg::ONE_LSB;
			lud_pkg::WR_DIV:  wr_data = lres_q;
			lud_pkg::WR_RDA:  wr_data = rda_q;
			lud_pkg::WR_RDB:  wr_data = rdb_q;
			default:          wr_data = rda_q;
		endcase
	end

	// Matrix store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[{cmd.wr_row, cmd.wr_col}] <= wr_data;
		end
		if (cmd.rd_en) begin
			rda_q <= mem_q[{cmd.a_row, cmd.a_col}];
			rdb_q <= mem_q[{cmd.b_row, cmd.b_col}];
		end
	end

	// Row scale table, running maximum and working registers.
	always_ff @(posedge clk) begin
		if (cmd.ld_en) begin
			scale_q[cmd.wr_row] <= rowmax_new;
			rowmax_q            <= rowmax_new;
		end
		if (cmd.swap) begin
			scale_q[best_q] <= scale_rd;
		end
		if (cmd.acc_load) begin
			acc_q <= {{(lud_pkg::ACC_W-lud_pkg::DATA_W){rda_q[lud_pkg::DATA_W-1]}}, rda_q};
		end else if (cmd.acc_sub) begin
			acc_q <= acc_q - lud_pkg::ACC_W'(prod_s1 >>> lud_pkg::FRAC_W);
		end
		if (cmd.mac_mul) begin
			prod_s1 <= $signed(rda_q) * $signed(rdb_q);
		end
		if (cmd.wr_en && cmd.wr_sel == lud_pkg::WR_ACC) begin
			v_q <= acc_sat;
		end
		if (cmd.piv_cap) begin
			piv_q <= (rda_q == '0) ? lud_pkg::ONE_LSB : rda_q;
		end
	end

	// Divider core: one quotient bit per cycle, restoring.
	assign trial    = {drem_q, dnum_q[lud_pkg::NUM_W-1]};
	assign diff     = trial - {1'b0, dden_q};
	assign trial_ge = trial >= {1'b0, dden_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dnum_q <= (cmd.div_mode == lud_pkg::DIV_MERIT)
				? {lud_pkg::mag_of(v_q), {lud_pkg::FRAC_W{1'b0}}}
				: {lud_pkg::mag_of(rda_q), {lud_pkg::FRAC_W{1'b0}}};
			dden_q  <= (cmd.div_mode == lud_pkg::DIV_MERIT) ? scale_rd : lud_pkg::mag_of(piv_q);
			dneg_q  <= (cmd.div_mode == lud_pkg::DIV_LOWER) &&
				(rda_q[lud_pkg::DATA_W-1] ^ piv_q[lud_pkg::DATA_W-1]);
			dmode_q <= cmd.div_mode;
			drem_q  <= '0;
			dcnt_q  <= '0;
		end else if (dbusy_q) begin
			dnum_q <= {dnum_q[lud_pkg::NUM_W-2:0], trial_ge};
			drem_q <= trial_ge ? diff[lud_pkg::DATA_W-1:0] : trial[lud_pkg::DATA_W-1:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	// Saturated quotient for pivot merit or lower factor.
	assign q_hi      = |dnum_q[lud_pkg::NUM_W-1:lud_pkg::DATA_W-1];
	assign q_neg_ovf = (|dnum_q[lud_pkg::NUM_W-1:lud_pkg::DATA_W]) ||
		(dnum_q[lud_pkg::DATA_W-1] && (|dnum_q[lud_pkg::DATA_W-2:0]));

	always_comb begin
		if (dmode_q == lud_pkg::DIV_LOWER && dneg_q) begin
			qsat = q_neg_ovf ? lud_pkg::SAT_MIN
				: (~dnum_q[lud_pkg::DATA_W-1:0] + lud_pkg::ONE_LSB);
		end else begin
			qsat = q_hi ? lud_pkg::SAT_MAX : dnum_q[lud_pkg::DATA_W-1:0];
		end
	end

	// Divider control and pivot search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q      <= 1'b0;
			ddone_q      <= 1'b0;
			best_merit_q <= '0;
			best_q       <= '0;
			zero_q       <= 1'b0;
			sign_q       <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
			end else if (dbusy_q && dcnt_q == lud_pkg::CNT_W'(lud_pkg::NUM_W - 1)) begin
				dbusy_q <= 1'b0;
				ddone_q <= 1'b1;
			end
			if (cmd.best_clr) begin
				best_merit_q <= '0;
			end else if (ddone_q && dmode_q == lud_pkg::DIV_MERIT && qsat >= best_merit_q) begin
				best_merit_q <= qsat;
				best_q       <= cmd.best_row;
			end
			if (cmd.ld_en) begin
				if (cmd.wr_row == '0 && cmd.wr_col == '0) begin
					zero_q <= cmd.ld_row_end && rowmax_new == '0;
				end else if (cmd.ld_row_end && rowmax_new == '0) begin
					zero_q <= 1'b1;
				end
			end
			if (cmd.sign_clr) begin
				sign_q <= 1'b0;
			end else if (cmd.swap) begin
				sign_q <= ~sign_q;
			end
		end
	end

	// Lower factor result, held for its write-back.
	always_ff @(posedge clk) begin
		if (ddone_q && dmode_q == lud_pkg::DIV_LOWER) begin
			lres_q <= qsat;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value        <= cmd.out_sing ? '0 : $signed(rda_q);
			row          <= cmd.out_sing ? '0 : cmd.out_row;
			column       <= cmd.out_sing ? '0 : cmd.out_col;
			det_negative <= cmd.out_sing ? 1'b0 : sign_q;
			singular     <= cmd.out_sing;
			last         <= cmd.out_last;
		end
	end

	assign status.div_done = ddone_q;
	assign status.singular = zero_q;
	assign status.rda_zero = (rda_q == '0);
	assign status.best_idx = best_q;

endmodule

`default_nettype wire

// ===== rtl/core/lud_ctrl.sv =====
// Controller: load counters, Crout sequencing, pivot swap and result emission.
`timescale 1ns / 1ps
`default_nettype none

module lud_ctrl (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_write_en,
	input  wire [lud_pkg::SIZE_W-1:0]         cfg_write_data,
	input  wire                               in_valid,
	output logic                              in_stall,
	output logic                              out_valid,
	input  wire                               out_stall,
	output lud_pkg::cmd_t                     cmd,
	input  lud_pkg::status_t                  status
);

	typedef enum logic [4:0] {
		S_LOAD,
		S_CHECK,
		S_SING,
		S_COL,
		S_RD_IJ,
		S_LD_ACC,
		S_RD_K,
		S_MUL,
		S_ACC,
		S_WB,
		S_MERIT,
		S_MWAIT,
		S_NEXT_I,
		S_SWAP_CHK,
		S_SWAP_RD,
		S_SWAP_W1,
		S_SWAP_W2,
		S_PIV_RD,
		S_PIV_CHK,
		S_L_RD,
		S_L_DIV,
		S_L_WAIT,
		S_L_WB,
		S_OUT_RD,
		S_OUT
	} state_t;

	state_t                    state_q;
	logic [lud_pkg::SIZE_W-1:0] size_q;
	lud_pkg::idx_t             n_m1;
	lud_pkg::idx_t             ldr_q;
	lud_pkg::idx_t             ldc_q;
	lud_pkg::idx_t             i_q;
	lud_pkg::idx_t             j_q;
	lud_pkg::idx_t             k_q;
	lud_pkg::idx_t             kmax_q;
	lud_pkg::idx_t             r_q;
	lud_pkg::idx_t             c_q;
	logic                      ovalid_q;
	logic                      accept;
	logic                      ld_last;
	logic                      out_free;

	// Size in use, clamped to one through the maximum.
	always_comb begin
		if (size_q == '0) begin
			n_m1 = '0;
		end else if (size_q > lud_pkg::SIZE_W'(lud_pkg::MAX_SIZE)) begin
			n_m1 = lud_pkg::IDX_W'(lud_pkg::MAX_SIZE - 1);
		end else begin
			n_m1 = lud_pkg::IDX_W'(size_q - 1'b1);
		end
	end

	assign in_stall  = (state_q != S_LOAD);
	assign accept    = in_valid && (state_q == S_LOAD);
	assign ld_last   = (ldr_q == n_m1) && (ldc_q == n_m1);
	assign out_free  = !ovalid_q || !out_stall;
	assign out_valid = ovalid_q;

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.best_row = i_q;
		cmd.sc_row   = i_q;
		unique case (state_q)
			S_LOAD: begin
				if (accept) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = lud_pkg::WR_ELEM;
					cmd.wr_row     = ldr_q;
					cmd.wr_col     = ldc_q;
					cmd.ld_en      = 1'b1;
					cmd.ld_row_end = (ldc_q == n_m1);
					cmd.sign_clr   = ld_last;
				end
			end
			S_SING: begin
				cmd.out_load = out_free;
				cmd.out_sing = 1'b1;
				cmd.out_last = 1'b1;
			end
			S_COL: begin
				cmd.best_clr = 1'b1;
			end
			S_RD_IJ, S_L_RD: begin
				cmd.rd_en = 1'b1;
				cmd.a_row = i_q;
				cmd.a_col = j_q;
			end
			S_LD_ACC: begin
				cmd.acc_load = 1'b1;
			end
			S_RD_K: begin
				cmd.rd_en = 1'b1;
				cmd.a_row = i_q;
				cmd.a_col = k_q;
				cmd.b_row = k_q;
				cmd.b_col = j_q;
			end
			S_MUL: begin
				cmd.mac_mul = 1'b1;
			end
			S_ACC: begin
				cmd.acc_sub = 1'b1;
			end
			S_WB: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = lud_pkg::WR_ACC;
				cmd.wr_row = i_q;
				cmd.wr_col = j_q;
			end
			S_MERIT: begin
				cmd.div_start = 1'b1;
				cmd.div_mode  = lud_pkg::DIV_MERIT;
			end
			S_SWAP_CHK: begin
				cmd.swap   = (status.best_idx != j_q);
				cmd.sc_row = j_q;
			end
			S_SWAP_RD: begin
				cmd.rd_en = 1'b1;
				cmd.a_row = j_q;
				cmd.a_col = k_q;
				cmd.b_row = status.best_idx;
				cmd.b_col = k_q;
			end
			S_SWAP_W1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = lud_pkg::WR_RDB;
				cmd.wr_row = j_q;
				cmd.wr_col = k_q;
			end
			S_SWAP_W2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = lud_pkg::WR_RDA;
				cmd.wr_row = status.best_idx;
				cmd.wr_col = k_q;
			end
			S_PIV_RD: begin
				cmd.rd_en = 1'b1;
				cmd.a_row = j_q;
				cmd.a_col = j_q;
			end
			S_PIV_CHK: begin
				cmd.piv_cap = 1'b1;
				cmd.wr_en   = status.rda_zero;
				cmd.wr_sel  = lud_pkg::WR_ONE;
				cmd.wr_row  = j_q;
				cmd.wr_col  = j_q;
			end
			S_L_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_mode  = lud_pkg::DIV_LOWER;
			end
			S_L_WB: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = lud_pkg::WR_DIV;
				cmd.wr_row = i_q;
				cmd.wr_col = j_q;
			end
			S_OUT_RD: begin
				cmd.rd_en = 1'b1;
				cmd.a_row = r_q;
				cmd.a_col = c_q;
			end
			S_OUT: begin
				cmd.out_load = out_free;
				cmd.out_row  = r_q;
				cmd.out_col  = c_q;
				cmd.out_last = (r_q == n_m1) && (c_q == n_m1);
			end
			default: begin
				cmd.best_clr = 1'b0;
			end
		endcase
	end

	// State, loop counters and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			size_q   <= lud_pkg::SIZE_W'(lud_pkg::MAX_SIZE);
			ldr_q    <= '0;
			ldc_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			kmax_q   <= '0;
			r_q      <= '0;
			c_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end

			if (cfg_write_en) begin
				size_q <= cfg_write_data;
				ldr_q  <= '0;
				ldc_q  <= '0;
			end else if (accept) begin
				if (ld_last) begin
					ldr_q <= '0;
					ldc_q <= '0;
				end else if (ldc_q == n_m1) begin
					ldc_q <= '0;
					ldr_q <= ldr_q + 1'b1;
				end else begin
					ldc_q <= ldc_q + 1'b1;
				end
			end

			unique case (state_q)
				S_LOAD: begin
					if (accept && ld_last && !cfg_write_en) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					j_q     <= '0;
					state_q <= status.singular ? S_SING : S_COL;
				end
				S_SING: begin
					if (out_free) begin
						state_q <= S_LOAD;
					end
				end
				S_COL: begin
					i_q     <= '0;
					state_q <= S_RD_IJ;
				end
				S_RD_IJ: begin
					k_q     <= '0;
					kmax_q  <= (i_q < j_q) ? i_q : j_q;
					state_q <= S_LD_ACC;
				end
				S_LD_ACC: begin
					state_q <= (kmax_q != '0) ? S_RD_K : S_WB;
				end
				S_RD_K: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (k_q == kmax_q - 1'b1) begin
						state_q <= S_WB;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RD_K;
					end
				end
				S_WB: begin
					state_q <= (i_q >= j_q) ? S_MERIT : S_NEXT_I;
				end
				S_MERIT: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (status.div_done) begin
						state_q <= S_NEXT_I;
					end
				end
				S_NEXT_I: begin
					if (i_q == n_m1) begin
						state_q <= S_SWAP_CHK;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RD_IJ;
					end
				end
				S_SWAP_CHK: begin
					k_q     <= '0;
					state_q <= (status.best_idx != j_q) ? S_SWAP_RD : S_PIV_RD;
				end
				S_SWAP_RD: begin
					state_q <= S_SWAP_W1;
				end
				S_SWAP_W1: begin
					state_q <= S_SWAP_W2;
				end
				S_SWAP_W2: begin
					if (k_q == n_m1) begin
						state_q <= S_PIV_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SWAP_RD;
					end
				end
				S_PIV_RD: begin
					state_q <= S_PIV_CHK;
				end
				S_PIV_CHK: begin
					if (j_q == n_m1) begin
						r_q     <= '0;
						c_q     <= '0;
						state_q <= S_OUT_RD;
					end else begin
						i_q     <= j_q + 1'b1;
						state_q <= S_L_RD;
					end
				end
				S_L_RD: begin
					state_q <= S_L_DIV;
				end
				S_L_DIV: begin
					state_q <= S_L_WAIT;
				end
				S_L_WAIT: begin
					if (status.div_done) begin
						state_q <= S_L_WB;
					end
				end
				S_L_WB: begin
					if (i_q == n_m1) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_COL;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_L_RD;
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						if (r_q == n_m1 && c_q == n_m1) begin
							state_q <= S_LOAD;
						end else begin
							if (c_q == n_m1) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
							state_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lud_checker.sv =====
// Port-level checker for the LU decomposition core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lud_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               out_valid,
	input wire               out_stall,
	input wire signed [31:0] value,
	input wire [2:0]         row,
	input wire [2:0]         column,
	input wire               det_negative,
	input wire               singular,
	input wire               last
);

	// A stalled result word stays valid and keeps its value, position and last flag.
	`LUD_ASSERT_NEXT(a_stall_valid, clk, arst_n, out_valid && out_stall, out_valid)
	`LUD_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && out_stall, $stable(value) && $stable(row) && $stable(column) && $stable(last))

	// A singular report is a lone, all-zero word.
	`LUD_ASSERT_IMPL(a_sing_word, clk, arst_n, out_valid && singular, last && value == 0 && row == 0 && column == 0 && !det_negative)

	// The final word of a decomposed matrix sits on the diagonal.
	`LUD_ASSERT_IMPL(a_last_diag, clk, arst_n, out_valid && last && !singular, row == column)

endmodule

bind lu_decompose_partial_pivot_core lud_checker u_lud_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.value       (value),
	.row         (row),
	.column      (column),
	.det_negative(det_negative),
	.singular    (singular),
	.last        (last)
);

`default_nettype wire
